// ===== hdl/x86enc_pkg.sv =====
// Package: shared types and opcode constants for the x86-64 instruction encoder.
`default_nettype none

package x86enc_pkg;

    localparam int MaxBytes = 10;
    localparam int IdxW     = 4;

    typedef logic [7:0] t_byte;

    // one encoded instruction: bytes in emit order, index of the final byte
    typedef struct packed {
        t_byte [MaxBytes-1:0] bytes;
        logic  [IdxW-1:0]     last_idx;
    } t_enc_rec;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    typedef enum logic [3:0] {
        FUNC_MOV_IMM64 = 4'd0,
        FUNC_PUSH      = 4'd1,
        FUNC_POP       = 4'd2,
        FUNC_SUB_IMM32 = 4'd3,
        FUNC_ADD_IMM32 = 4'd4,
        FUNC_RET       = 4'd5,
        FUNC_CMP       = 4'd6,
        FUNC_TEST      = 4'd7,
        FUNC_JMP       = 4'd8,
        FUNC_JNE       = 4'd9,
        FUNC_JE        = 4'd10,
        FUNC_CALL      = 4'd11,
        FUNC_NOP       = 4'd12,
        FUNC_MOVSS     = 4'd13,
        FUNC_ADDSS     = 4'd14,
        FUNC_MULSS     = 4'd15
    } t_func;

    localparam t_byte REX_BASE     = 8'h40;
    localparam t_byte REX_W        = 8'h48;
    localparam t_byte REX_B        = 8'h41;
    localparam t_byte OP_MOV_IMM   = 8'hB8;
    localparam t_byte OP_PUSH      = 8'h50;
    localparam t_byte OP_POP       = 8'h58;
    localparam t_byte OP_ALU_IMM   = 8'h81;
    localparam t_byte MODRM_SUB    = 8'hE8;
    localparam t_byte MODRM_DIRECT = 8'hC0;
    localparam t_byte OP_RET       = 8'hC3;
    localparam t_byte OP_CMP       = 8'h39;
    localparam t_byte OP_TEST      = 8'h85;
    localparam t_byte OP_JMP       = 8'hE9;
    localparam t_byte OP_ESC       = 8'h0F;
    localparam t_byte OP_JNE       = 8'h85;
    localparam t_byte OP_JE        = 8'h84;
    localparam t_byte OP_CALL      = 8'hFF;
    localparam t_byte MODRM_CALL   = 8'hD0;
    localparam t_byte OP_NOP       = 8'h90;
    localparam t_byte PFX_SSE      = 8'hF3;
    localparam t_byte OP_MOVSS     = 8'h10;
    localparam t_byte OP_ADDSS     = 8'h58;
    localparam t_byte OP_MULSS     = 8'h59;

endpackage

`default_nettype wire

// ===== hdl/x86enc_front.sv =====
// Front end: accepts a request and classifies it into an encoded byte record.
`default_nettype none

module x86enc_front
    import x86enc_pkg::*;
(
    input  wire logic        start,
    input  wire logic [3:0]  i_func,
    input  wire logic [3:0]  i_first_reg,
    input  wire logic [3:0]  i_second_reg,
    input  wire logic [63:0] i_immediate,
    input  wire t_q_status   i_q_status,
    output logic             o_push,
    output t_enc_rec         o_rec
);

    t_byte opb;
    t_byte rex_sse;
    t_byte modrm_rr;

    assign o_push = start && !i_q_status.full;

    always_comb begin
        o_rec    = '0;
        opb      = '0;
        rex_sse  = REX_BASE | {5'b0, i_first_reg[3], 1'b0, i_second_reg[3]};
        modrm_rr = MODRM_DIRECT | {2'b0, i_second_reg[2:0], i_first_reg[2:0]};
        case (t_func'(i_func))
            FUNC_MOV_IMM64: begin
                o_rec.bytes[0]   = REX_W | {7'b0, i_first_reg[3]};
                o_rec.bytes[1]   = OP_MOV_IMM | {5'b0, i_first_reg[2:0]};
                // imm64, little-endian
                o_rec.bytes[9:2] = i_immediate;
                o_rec.last_idx   = 4'd9;
            end
            FUNC_PUSH, FUNC_POP, FUNC_CALL: begin
                case (t_func'(i_func))
                    FUNC_PUSH: opb = OP_PUSH | {5'b0, i_first_reg[2:0]};
                    FUNC_POP:  opb = OP_POP | {5'b0, i_first_reg[2:0]};
                    default:   opb = OP_CALL;
                endcase
                if (i_first_reg[3]) begin
                    o_rec.bytes[0] = REX_B;
                    o_rec.bytes[1] = opb;
                    o_rec.last_idx = 4'd1;
                end else begin
                    o_rec.bytes[0] = opb;
                    o_rec.last_idx = 4'd0;
                end
                // call reg carries a ModRM after the opcode
                if (t_func'(i_func) == FUNC_CALL) begin
                    o_rec.bytes[{3'b0, i_first_reg[3]} + 4'd1] =
                        MODRM_CALL | {5'b0, i_first_reg[2:0]};
                    o_rec.last_idx = o_rec.last_idx + 4'd1;
                end
            end
            FUNC_SUB_IMM32, FUNC_ADD_IMM32: begin
                o_rec.bytes[0] = REX_W | {7'b0, i_first_reg[3]};
                o_rec.bytes[1] = OP_ALU_IMM;
                o_rec.bytes[2] = ((t_func'(i_func) == FUNC_SUB_IMM32) ? MODRM_SUB : MODRM_DIRECT)
                                 | {5'b0, i_first_reg[2:0]};
                o_rec.bytes[6:3] = i_immediate[31:0];
                o_rec.last_idx = 4'd6;
            end
            FUNC_RET: begin
                o_rec.bytes[0] = OP_RET;
                o_rec.last_idx = 4'd0;
            end
            FUNC_CMP, FUNC_TEST: begin
                o_rec.bytes[0] = REX_W | {5'b0, i_second_reg[3], 1'b0, i_first_reg[3]};
                o_rec.bytes[1] = (t_func'(i_func) == FUNC_CMP) ? OP_CMP : OP_TEST;
                o_rec.bytes[2] = modrm_rr;
                o_rec.last_idx = 4'd2;
            end
            FUNC_JMP: begin
                o_rec.bytes[0]   = OP_JMP;
                o_rec.bytes[4:1] = i_immediate[31:0];
                o_rec.last_idx   = 4'd4;
            end
            FUNC_JNE, FUNC_JE: begin
                o_rec.bytes[0]   = OP_ESC;
                o_rec.bytes[1]   = (t_func'(i_func) == FUNC_JNE) ? OP_JNE : OP_JE;
                o_rec.bytes[5:2] = i_immediate[31:0];
                o_rec.last_idx   = 4'd5;
            end
            FUNC_NOP: begin
                o_rec.bytes[0] = OP_NOP;
                o_rec.last_idx = 4'd0;
            end
            default: begin
                // SSE scalar forms; REX sits after F3 and only when R or B is set
                case (t_func'(i_func))
                    FUNC_MOVSS: opb = OP_MOVSS;
                    FUNC_ADDSS: opb = OP_ADDSS;
                    default:    opb = OP_MULSS;
                endcase
                // ModRM: reg = xmm destination, rm = xmm source
                modrm_rr = MODRM_DIRECT | {2'b0, i_first_reg[2:0], i_second_reg[2:0]};
                o_rec.bytes[0] = PFX_SSE;
                if (rex_sse != REX_BASE) begin
                    o_rec.bytes[1] = rex_sse;
                    o_rec.bytes[2] = OP_ESC;
                    o_rec.bytes[3] = opb;
                    o_rec.bytes[4] = modrm_rr;
                    o_rec.last_idx = 4'd4;
                end else begin
                    o_rec.bytes[1] = OP_ESC;
                    o_rec.bytes[2] = opb;
                    o_rec.bytes[3] = modrm_rr;
                    o_rec.last_idx = 4'd3;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/x86enc_queue.sv =====
// Two-entry record queue between the front end and the byte emitter.
`default_nettype none

module x86enc_queue
    import x86enc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_enc_rec i_rec,
    input  wire logic     i_pop,
    output t_enc_rec      o_rec,
    output t_q_status     o_status
);

    t_enc_rec   r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_rec           = r_mem[r_rd_ptr];
    assign o_status.empty  = (r_count == 2'd0);
    assign o_status.full   = (r_count == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/x86enc_back.sv =====
// Back end: walks an encoded record and emits one code byte per cycle.
`default_nettype none

module x86enc_back
    import x86enc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_enc_rec  i_rec,
    input  wire t_q_status i_q_status,
    output logic           o_pop,
    output logic           o_strobe,
    output logic [7:0]     o_code_byte,
    output logic           o_last_byte
);

    t_enc_rec        r_rec;
    logic [IdxW-1:0] r_idx;
    logic            r_active;
    logic            r_strobe;
    logic            r_last;
    t_byte           r_code_byte;
    logic            at_last;

    assign at_last = (r_idx == r_rec.last_idx);
    // next record loads in the same cycle the current one finishes
    assign o_pop   = !i_q_status.empty && (!r_active || at_last);

    assign o_strobe    = r_strobe;
    assign o_last_byte = r_last;
    assign o_code_byte = r_code_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_strobe <= r_active;
            r_last   <= r_active && at_last;
            if (o_pop) begin
                r_active <= 1'b1;
                r_idx    <= '0;
            end else if (r_active && at_last) begin
                r_active <= 1'b0;
            end else if (r_active) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_rec;
        end
        r_code_byte <= r_rec.bytes[r_idx];
    end

endmodule

`default_nettype wire

// ===== hdl/x86_64_instruction_encoder.sv =====
// Top level: x86-64 instruction encoder, front end, record queue and byte emitter.
`default_nettype none

// Usage
//   Request channel: drive i_func, i_first_reg, i_second_reg, i_immediate and
//   raise start; the transaction is taken at a rising edge with start high and
//   busy low. busy is high only while the two-entry record queue is full.
//   Result channel: one machine code byte per cycle on o_code_byte, marked by
//   o_strobe for exactly one cycle; o_last_byte flags the final byte of each
//   instruction. The receiver cannot stall, so every strobed byte is taken.
//   When the emitter is idle, the first byte of a request passes through the
//   queue write, the record load and the output register.
//   Throughput: an instruction of 1 to 10 bytes holds the emitter while it walks
//   those bytes; the emitter's one-byte-per-cycle walk sets the rate, and the next
//   record loads on the cycle the current one ends, so queued instructions follow
//   with no gap. Requests are taken every cycle until the queue fills.
//   Reset (synchronous, active low) empties the queue and idles the emitter;
//   no strobe is issued until a new request arrives.

module x86_64_instruction_encoder
    import x86enc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [3:0]  i_func,
    input  wire logic [3:0]  i_first_reg,
    input  wire logic [3:0]  i_second_reg,
    input  wire logic [63:0] i_immediate,
    output logic             o_strobe,
    output logic [7:0]       o_code_byte,
    output logic             o_last_byte
);

    t_enc_rec  front_rec;
    t_enc_rec  q_rec;
    t_q_status q_status;
    logic      push;
    logic      pop;

    assign busy = q_status.full;

    // classify the request into a complete byte record
    x86enc_front u_front (
        .start        (start),
        .i_func       (i_func),
        .i_first_reg  (i_first_reg),
        .i_second_reg (i_second_reg),
        .i_immediate  (i_immediate),
        .i_q_status   (q_status),
        .o_push       (push),
        .o_rec        (front_rec)
    );

    // decouples acceptance from byte emission
    x86enc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_rec    (front_rec),
        .i_pop    (pop),
        .o_rec    (q_rec),
        .o_status (q_status)
    );

    // one byte per cycle out of the head record
    x86enc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (q_rec),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_strobe    (o_strobe),
        .o_code_byte (o_code_byte),
        .o_last_byte (o_last_byte)
    );

endmodule

`default_nettype wire

// ===== hdl/x86enc_checker.sv =====
// Checker: port-level assertions for the encoder, bound to the top level.
`default_nettype none

module x86enc_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_strobe,
    input wire logic o_last_byte
);

    // reset leaves the block empty and silent
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_strobe)
        else $error("busy or strobe after reset");

    // a flag on the final byte only comes with a byte
    a_last_has_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_byte |-> o_strobe)
        else $error("last byte flag without strobe");

    // bytes of one instruction leave in consecutive cycles
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_byte |=> o_strobe)
        else $error("gap inside an instruction");

    // a burst after idle: accepted request via queue, record, output regs
    a_burst_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_strobe) |-> $past(start && !busy, 3))
        else $error("output burst without an accepted transaction");

endmodule

bind x86_64_instruction_encoder x86enc_checker u_x86enc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_strobe    (o_strobe),
    .o_last_byte (o_last_byte)
);

`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for the x86-64 instruction encoder: directed and random requests, byte-level checks.
`timescale 1ns / 1ps

import x86enc_pkg::*;

// Holds the expected byte stream and checks every strobed byte against it, in order.
class InstrByteScoreboard;

    typedef struct packed {
        logic  last;
        t_byte code;
    } t_code_exp;

    t_code_exp pending_bytes[$];
    int        errors;

    function new();
        errors = 0;
    endfunction

    // Only the first ten failures are printed; the rest are just counted.
    function void flag(string msg);
        errors++;
        if (errors <= 10)
            $display("[%0t] ERROR: %s", $time, msg);
    endfunction

    function int pending_count();
        return pending_bytes.size();
    endfunction

    // Works out the machine code of one accepted request and queues it.
    function void note_request(t_func f, logic [3:0] r1, logic [3:0] r2, logic [63:0] imm);
        t_byte     seq[$];
        t_byte     rex;
        t_code_exp item;
        seq = {};
        case (f)
            FUNC_MOV_IMM64: begin
                seq = {seq, REX_W | {7'd0, r1[3]}};
                seq = {seq, OP_MOV_IMM + {5'd0, r1[2:0]}};
                for (int i = 0; i < 8; i++)
                    seq = {seq, imm[8*i +: 8]};
            end
            FUNC_PUSH, FUNC_POP: begin
                // REX.B only for the upper eight registers
                if (r1[3])
                    seq = {seq, REX_B};
                seq = {seq, ((f == FUNC_PUSH) ? OP_PUSH : OP_POP) + {5'd0, r1[2:0]}};
            end
            FUNC_SUB_IMM32, FUNC_ADD_IMM32: begin
                seq = {seq, REX_W | {7'd0, r1[3]}};
                seq = {seq, OP_ALU_IMM};
                seq = {seq, ((f == FUNC_SUB_IMM32) ? MODRM_SUB : MODRM_DIRECT)
                            | {5'd0, r1[2:0]}};
                for (int i = 0; i < 4; i++)
                    seq = {seq, imm[8*i +: 8]};
            end
            FUNC_RET:
                seq = {seq, OP_RET};
            FUNC_CMP, FUNC_TEST: begin
                // second_reg goes in ModRM.reg (REX.R), first_reg in ModRM.rm (REX.B)
                seq = {seq, REX_W | {5'd0, r2[3], 1'b0, r1[3]}};
                seq = {seq, (f == FUNC_CMP) ? OP_CMP : OP_TEST};
                seq = {seq, MODRM_DIRECT | {2'd0, r2[2:0], r1[2:0]}};
            end
            FUNC_JMP: begin
                seq = {seq, OP_JMP};
                for (int i = 0; i < 4; i++)
                    seq = {seq, imm[8*i +: 8]};
            end
            FUNC_JNE, FUNC_JE: begin
                seq = {seq, OP_ESC};
                seq = {seq, (f == FUNC_JNE) ? OP_JNE : OP_JE};
                for (int i = 0; i < 4; i++)
                    seq = {seq, imm[8*i +: 8]};
            end
            FUNC_CALL: begin
                if (r1[3])
                    seq = {seq, REX_B};
                seq = {seq, OP_CALL};
                seq = {seq, MODRM_CALL | {5'd0, r1[2:0]}};
            end
            FUNC_NOP:
                seq = {seq, OP_NOP};
            default: begin
                // SSE scalar forms: F3, optional REX after it, 0F, opcode, ModRM
                rex = REX_BASE | {5'd0, r1[3], 1'b0, r2[3]};
                seq = {seq, PFX_SSE};
                if (rex != REX_BASE)
                    seq = {seq, rex};
                seq = {seq, OP_ESC};
                case (f)
                    FUNC_MOVSS: seq = {seq, OP_MOVSS};
                    FUNC_ADDSS: seq = {seq, OP_ADDSS};
                    default:    seq = {seq, OP_MULSS};
                endcase
                seq = {seq, MODRM_DIRECT | {2'd0, r1[2:0], r2[2:0]}};
            end
        endcase
        foreach (seq[i]) begin
            item.code = seq[i];
            item.last = (i == seq.size() - 1);
            pending_bytes = {pending_bytes, item};
        end
    endfunction

    function void check_byte(t_byte code, logic last);
        t_code_exp want;
        if (pending_bytes.size() == 0) begin
            flag($sformatf("unexpected byte %02h last=%0b", code, last));
            return;
        end
        want = pending_bytes.pop_front();
        if (code !== want.code)
            flag($sformatf("code_byte: expected %02h, got %02h", want.code, code));
        if (last !== want.last)
            flag($sformatf("last_byte: expected %0b, got %0b (byte %02h)",
                           want.last, last, want.code));
    endfunction
endclass

module testbench;
    import x86enc_pkg::*;

    localparam int StallLimit  = 2000;  // cycles with no transaction on either side
    localparam int DrainCycles = 16;    // extra settle time after the last expected byte
    localparam int RandomItems = 380;

    // Everything starts at a known value; reset held low from time zero.
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        start        = 1'b0;
    logic [3:0]  i_func       = '0;
    logic [3:0]  i_first_reg  = '0;
    logic [3:0]  i_second_reg = '0;
    logic [63:0] i_immediate  = '0;
    logic        busy;
    logic        o_strobe;
    logic [7:0]  o_code_byte;
    logic        o_last_byte;

    InstrByteScoreboard sb = new();

    // When set, requests go back to back so the record queue fills and busy kicks in.
    bit no_gap   = 1'b0;
    int idle_cnt = 0;

    always #2 i_clk = ~i_clk;

    x86_64_instruction_encoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_first_reg  (i_first_reg),
        .i_second_reg (i_second_reg),
        .i_immediate  (i_immediate),
        .o_strobe     (o_strobe),
        .o_code_byte  (o_code_byte),
        .o_last_byte  (o_last_byte)
    );

    // Result side: the receiver cannot stall, so every strobed byte is a transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1)
            sb.check_byte(o_code_byte, o_last_byte);
    end

    // Watchdog: counts edges where neither a request nor a byte is taken.
    always @(posedge i_clk) begin
        if ((start && !busy && i_rst_n) || o_strobe === 1'b1) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= StallLimit) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    // One request transaction. A random pause (unless in a burst) comes first; start
    // stays high across back-to-back transactions so it is never dropped and re-raised
    // within one time step. Acceptance is sampled at the edge: start high, busy low.
    task automatic send_instr(input t_func f, input logic [3:0] r1, input logic [3:0] r2,
                              input logic [63:0] imm);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 29) == 0)
            no_gap = !no_gap;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_func       <= f;
        i_first_reg  <= r1;
        i_second_reg <= r2;
        i_immediate  <= imm;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        sb.note_request(f, r1, r2, imm);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every operation, register extremes on both sides of REX,
        // immediate extremes, unused operands nonzero, upper immediate bits set
        // on the 32-bit forms.
        send_instr(FUNC_MOV_IMM64, 4'd15, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
        send_instr(FUNC_MOV_IMM64, 4'd0,  4'd0,  64'h0);
        send_instr(FUNC_MOV_IMM64, 4'd7,  4'd8,  64'h0123_4567_89AB_CDEF);
        send_instr(FUNC_PUSH,      4'd0,  4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
        send_instr(FUNC_PUSH,      4'd15, 4'd0,  64'h0);
        send_instr(FUNC_POP,       4'd8,  4'd7,  64'h0);
        send_instr(FUNC_POP,       4'd7,  4'd0,  64'h0);
        send_instr(FUNC_SUB_IMM32, 4'd15, 4'd15, 64'hDEAD_BEEF_FFFF_FFFF);
        send_instr(FUNC_SUB_IMM32, 4'd0,  4'd0,  64'h0);
        send_instr(FUNC_ADD_IMM32, 4'd9,  4'd3,  64'h5555_5555_AAAA_AAAA);
        send_instr(FUNC_ADD_IMM32, 4'd4,  4'd0,  64'h8000_0000);
        send_instr(FUNC_RET,       4'd15, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
        send_instr(FUNC_CMP,       4'd15, 4'd15, 64'h0);
        send_instr(FUNC_CMP,       4'd0,  4'd0,  64'hFFFF_FFFF_FFFF_FFFF);
        send_instr(FUNC_TEST,      4'd0,  4'd8,  64'h0);
        send_instr(FUNC_TEST,      4'd13, 4'd2,  64'h0);
        send_instr(FUNC_JMP,       4'd15, 4'd15, 64'hFFFF_FFFF_8000_0000);
        send_instr(FUNC_JNE,       4'd3,  4'd12, 64'h1234_5678_7FFF_FFFF);
        send_instr(FUNC_JE,        4'd0,  4'd0,  64'hFFFF_FFFF_FFFF_FFFE);
        send_instr(FUNC_CALL,      4'd15, 4'd0,  64'h0);
        send_instr(FUNC_CALL,      4'd0,  4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
        send_instr(FUNC_NOP,       4'd15, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
        send_instr(FUNC_MOVSS,     4'd0,  4'd0,  64'h0);   // no REX needed
        send_instr(FUNC_ADDSS,     4'd15, 4'd0,  64'h0);   // REX.R only
        send_instr(FUNC_MULSS,     4'd0,  4'd15, 64'h0);   // REX.B only

        // Random: uniform operations, registers and full 64-bit immediates.
        for (int n = 0; n < RandomItems; n++)
            send_instr(t_func'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                       4'($urandom_range(0, 15)), {$urandom, $urandom});
        start <= 1'b0;

        // Drain: wait for the last expected byte, then make sure nothing extra follows.
        while (sb.pending_count() != 0)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (sb.pending_count() != 0)
            sb.flag($sformatf("%0d expected bytes never arrived", sb.pending_count()));
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/x86enc_pkg.sv
hdl/x86enc_front.sv
hdl/x86enc_queue.sv
hdl/x86enc_back.sv
hdl/x86_64_instruction_encoder.sv
hdl/x86enc_checker.sv
test/testbench.sv
